// ----- src/tkl_pkg.sv -----
// Shared types and constants for the top-K lattice path search.
package tkl_pkg;
  localparam int MaxPos    = 32;
  localparam int KeepMax   = 4;
  localparam int ChoiceW   = 16;
  localparam int PosW      = 5;
  localparam int SlotW     = 2;
  localparam int SlotCntW  = 3;
  localparam int ScoreW    = 32;
  localparam int AddrW     = PosW + SlotW;
  localparam int LinkW     = SlotW + PosW + ChoiceW;
  localparam int StackW    = 5;

  localparam logic [1:0] FuncStart = 2'd0;
  localparam logic [1:0] FuncEdge  = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  // Datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SRC_RD,
    CMD_DST_RD,
    CMD_DST_SCAN,
    CMD_DST_WR,
    CMD_FIN_RD,
    CMD_FIN_PRE,
    CMD_FIN_SCAN,
    CMD_BT_RD,
    CMD_BT_STEP,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [SlotW-1:0]     slot;
  } ctl_t;

  typedef struct packed {
    logic src_valid;
    logic edge_ok;
    logic found;
    logic bt_done;
    logic bt_bad;
    logic emit_last;
  } sts_t;
endpackage

// ----- src/top_k_lattice_path_search.sv -----
// Top level of the top-K lattice path search.
// Busy after a word is taken. Start clears the lattice. Edge: per kept source entry,
// read it, then prefetch and scan the end slots and write; a skipped edge or invalid
// source ends it. Read: rank each final entry, backtrack, then one word per cycle
// while output is free. One item in flight at a time; output register holds one word.
// rst_n (synchronous) clears valid bits, registers to 1/1, controller idle.
module top_k_lattice_path_search
  import tkl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[1:0], start_pos[6:2], edge_len[11:7], edge_score[43:12],
  // choice_id[59:44], rank[61:60]
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // path_choice[15:0], path_score[47:16]
  output logic [47:0] out_tdata,
  // status[0]
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  logic [4:0] slen_r;
  logic [2:0] keep_r;
  logic [PosW-1:0] len_eff;
  logic [SlotCntW-1:0] keep_eff;
  logic busy, in_fire, emit, emit_np, emit_last, no_path;
  ctl_t ctl;
  sts_t sts;
  logic [ChoiceW-1:0] pc;
  logic signed [ScoreW-1:0] ps;
  logic [63:0] in_hold_r;

  assign cfg_ready = 1'b1;
  // Hold config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slen_r <= 5'd1; keep_r <= 3'd1;
    end else if (cfg_valid) begin
      if (cfg_index == 1'b0) slen_r <= cfg_data[4:0];
      else keep_r <= cfg_data[2:0];
    end
  end
  assign len_eff  = (slen_r == '0) ? 5'd1 : slen_r;
  assign keep_eff = (keep_r == '0) ? 3'd1 : (keep_r > 3'd4 ? 3'd4 : keep_r);

  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  always_ff @(posedge clk) if (in_fire) in_hold_r <= in_tdata;

  tkl_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .func(in_tdata[1:0]), .keep_eff, .sts,
    .out_free(!out_tvalid || out_tready), .busy, .ctl, .emit,
    .emit_nopath(emit_np), .emit_last
  );

  tkl_datapath u_dp (
    .clk, .rst_n, .ctl, .len_eff, .keep_eff,
    .start_pos(in_hold_r[6:2]), .edge_len(in_hold_r[11:7]),
    .edge_score(in_hold_r[43:12]), .choice_id(in_hold_r[59:44]),
    .rank(in_hold_r[61:60]), .sts, .path_choice(pc), .path_score(ps), .no_path
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (emit) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
    if (emit) begin
      out_tdata <= (emit_np || no_path) ? 48'd0 : {ps, pc};
      out_tuser <= emit_np;
      out_tlast <= emit_last;
    end
  end
endmodule

// ----- src/tkl_datapath.sv -----
// Lattice storage, score compare, ranking and backtrack datapath.
module tkl_datapath
  import tkl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  input  logic [PosW-1:0]          len_eff,
  input  logic [SlotCntW-1:0]      keep_eff,
  input  logic [PosW-1:0]          start_pos,
  input  logic [PosW-1:0]          edge_len,
  input  logic signed [ScoreW-1:0] edge_score,
  input  logic [ChoiceW-1:0]       choice_id,
  input  logic [SlotW-1:0]         rank,
  output sts_t                     sts,
  output logic [ChoiceW-1:0]       path_choice,
  output logic signed [ScoreW-1:0] path_score,
  output logic                     no_path
);
  logic signed [ScoreW-1:0] score_mem [MaxPos*KeepMax];
  logic [LinkW-1:0]         link_mem [MaxPos*KeepMax];
  logic [ChoiceW-1:0]       stack_mem [32];
  logic [KeepMax-1:0]       valid_r [MaxPos];

  logic [PosW-1:0]          st_r, ln_r, end_r, pos_r;
  logic signed [ScoreW-1:0] esc_r, cand_r, rd_score_r, min_r, tot_r;
  logic [ChoiceW-1:0]       ch_r;
  logic [SlotW-1:0]         rank_r, mi_r, cur_r, slot_r, src_k_r;
  logic                     mv_r, found_r;
  logic [2:0]               place_r;
  logic [LinkW-1:0]         rd_link_r;
  logic [StackW:0]          n_r;
  logic [StackW:0]          out_i_r;
  logic [ChoiceW-1:0]       rd_stack_r;
  logic                     bt_bad_r;

  logic [AddrW-1:0]         rd_addr;
  logic [StackW-1:0]        stk_addr;
  logic signed [ScoreW:0]   sum_w;
  logic signed [ScoreW-1:0] sat_w;
  logic                     tv;
  logic                     dst_wr;

  // Saturating 32-bit add of source score and edge score
  assign sum_w = {rd_score_r[ScoreW-1], rd_score_r} + {esc_r[ScoreW-1], esc_r};
  always_comb begin
    if (sum_w[ScoreW] != sum_w[ScoreW-1])
      sat_w = sum_w[ScoreW] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    else
      sat_w = sum_w[ScoreW-1:0];
  end

  // Read address by command; scans fetch the next slot in the cycle before it is compared
  always_comb begin
    case (ctl.cmd)
      CMD_SRC_RD:   rd_addr = {st_r, ctl.slot};
      CMD_DST_RD:   rd_addr = {end_r, ctl.slot};
      CMD_DST_SCAN: rd_addr = {end_r, ctl.slot + 1'b1};
      CMD_FIN_RD:   rd_addr = {len_eff, ctl.slot};
      CMD_FIN_PRE:  rd_addr = {len_eff, ctl.slot};
      CMD_FIN_SCAN: rd_addr = {len_eff, ctl.slot + 1'b1};
      CMD_BT_RD:    rd_addr = {pos_r, found_r ? slot_r : cur_r};
      default:      rd_addr = {st_r, ctl.slot};
    endcase
  end

  // Stack read address: first word at the end of backtrack, next word on emit
  always_comb begin
    case (ctl.cmd)
      CMD_BT_STEP: stk_addr = n_r[StackW-1:0] - 1'b1;
      CMD_EMIT:    stk_addr = out_i_r[StackW-1:0] - 1'b1;
      default:     stk_addr = out_i_r[StackW-1:0];
    endcase
  end

  assign tv = valid_r[end_r][ctl.slot];
  assign dst_wr = (ctl.cmd == CMD_DST_WR) && (!mv_r || cand_r > min_r);

  // Registered memory reads and memory writes
  always_ff @(posedge clk) begin
    rd_score_r <= score_mem[rd_addr];
    rd_link_r  <= link_mem[rd_addr];
    rd_stack_r <= stack_mem[stk_addr];
    if (dst_wr)
      score_mem[{end_r, mi_r}] <= cand_r;
    if (dst_wr)
      link_mem[{end_r, mi_r}] <= {src_k_r, ln_r, ch_r};
    if (ctl.cmd == CMD_CLEAR) begin
      score_mem[{AddrW{1'b0}}] <= '0;
      link_mem[{AddrW{1'b0}}]  <= '0;
    end
    if (ctl.cmd == CMD_BT_STEP && !bt_bad_r && pos_r != '0)
      stack_mem[n_r[StackW-1:0]] <= rd_link_r[ChoiceW-1:0];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < MaxPos; p++) valid_r[p] <= '0;
    end else if (ctl.cmd == CMD_CLEAR) begin
      for (int p = 0; p < MaxPos; p++) valid_r[p] <= '0;
      valid_r[0] <= {{(KeepMax-1){1'b0}}, 1'b1};
    end else if (dst_wr) begin
      valid_r[end_r][mi_r] <= 1'b1;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD: begin
        st_r <= start_pos; ln_r <= edge_len; end_r <= start_pos + edge_len;
        esc_r <= edge_score; ch_r <= choice_id; rank_r <= rank;
        found_r <= 1'b0; pos_r <= len_eff; n_r <= '0; bt_bad_r <= 1'b0;
      end
      CMD_SRC_RD: src_k_r <= ctl.slot;
      CMD_DST_RD: begin
        // rd_score_r holds the source score
        cand_r <= sat_w; mi_r <= '0; mv_r <= 1'b0;
      end
      CMD_DST_SCAN: begin
        // rd_score_r holds the score of end slot ctl.slot
        if (ctl.slot == '0) begin
          mi_r <= '0; mv_r <= tv; min_r <= rd_score_r;
        end else if (mv_r && (!tv || rd_score_r < min_r)) begin
          mi_r <= ctl.slot; mv_r <= tv; min_r <= rd_score_r;
        end
      end
      CMD_FIN_RD: begin
        place_r <= '0; cur_r <= ctl.slot;
      end
      CMD_FIN_PRE: min_r <= rd_score_r;
      CMD_FIN_SCAN: begin
        // compare slot cur_r (in min_r) against slot ctl.slot (in rd_score_r)
        if (valid_r[len_eff][ctl.slot] && ctl.slot != cur_r &&
            (rd_score_r > min_r || (rd_score_r == min_r && ctl.slot < cur_r)))
          place_r <= place_r + 3'd1;
      end
      CMD_BT_RD: begin
        // first read latches the ranking result
        if (!found_r) begin
          found_r <= 1'b1; slot_r <= cur_r; tot_r <= min_r;
        end
      end
      CMD_BT_STEP: begin
        if (pos_r != '0) begin
          if (!valid_r[pos_r][slot_r] || rd_link_r[ChoiceW +: PosW] == '0 ||
              rd_link_r[ChoiceW +: PosW] > pos_r || n_r[StackW])
            bt_bad_r <= 1'b1;
          else begin
            n_r <= n_r + 1'b1;
            slot_r <= rd_link_r[LinkW-1 -: SlotW];
            pos_r <= pos_r - rd_link_r[ChoiceW +: PosW];
          end
        end
        out_i_r <= n_r - 1'b1;
      end
      CMD_EMIT: out_i_r <= out_i_r - 1'b1;
      default: ;
    endcase
  end

  assign sts.src_valid = valid_r[st_r][ctl.slot];
  assign sts.edge_ok   = (ln_r != '0) && ({1'b0, st_r} + {1'b0, ln_r} <= {1'b0, len_eff});
  assign sts.found     = (rank_r < keep_eff[SlotW-1:0] || keep_eff[SlotW]) &&
                         valid_r[len_eff][cur_r] && place_r == {1'b0, rank_r};
  assign sts.bt_done   = (pos_r == '0) || bt_bad_r;
  assign sts.bt_bad    = bt_bad_r || n_r == '0;
  assign sts.emit_last = out_i_r == '0;

  assign path_choice = rd_stack_r;
  assign path_score  = tot_r;
  assign no_path     = 1'b0;
endmodule

// ----- src/tkl_ctrl.sv -----
// Sequencer for start, edge and read items.
module tkl_ctrl
  import tkl_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [1:0]          func,
  input  logic [SlotCntW-1:0] keep_eff,
  input  sts_t                sts,
  input  logic                out_free,
  output logic                busy,
  output ctl_t                ctl,
  output logic                emit,
  output logic                emit_nopath,
  output logic                emit_last
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SRC, S_FPRE, S_DRD, S_DSCAN, S_DWR,
    S_FRD, S_FSCAN, S_FCHK, S_BRD, S_BSTEP, S_EMIT, S_NOPATH
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       func_r, func_nxt;
  logic [SlotW-1:0] k_r, k_nxt, t_r, t_nxt;
  logic [SlotW-1:0] kmax;

  assign kmax = keep_eff[SlotW-1:0] - 1'b1;

  // Next state and commands
  always_comb begin
    state_nxt = state_r; func_nxt = func_r; k_nxt = k_r; t_nxt = t_r;
    ctl.cmd = CMD_NONE; ctl.slot = t_r;
    emit = 1'b0; emit_nopath = 1'b0; emit_last = 1'b0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        func_nxt = func; state_nxt = S_LOAD;
      end
      S_LOAD: begin
        ctl.cmd = CMD_LOAD; k_nxt = '0; t_nxt = '0;
        case (func_r)
          FuncStart: begin ctl.cmd = CMD_CLEAR; state_nxt = S_IDLE; end
          FuncEdge:  state_nxt = S_SRC;
          FuncRead:  state_nxt = S_FRD;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_SRC: begin
        ctl.slot = k_r;
        if (!sts.edge_ok || !sts.src_valid) state_nxt = S_IDLE;
        else begin ctl.cmd = CMD_SRC_RD; state_nxt = S_DRD; t_nxt = '0; end
      end
      S_DRD: begin
        ctl.cmd = CMD_DST_RD; state_nxt = S_DSCAN;
      end
      S_DSCAN: begin
        ctl.cmd = CMD_DST_SCAN;
        if (t_r == kmax) state_nxt = S_DWR; else t_nxt = t_r + 1'b1;
      end
      S_DWR: begin
        ctl.cmd = CMD_DST_WR;
        if (k_r == kmax) state_nxt = S_IDLE;
        else begin k_nxt = k_r + 1'b1; state_nxt = S_SRC; end
      end
      S_FRD: begin
        ctl.cmd = CMD_FIN_RD; ctl.slot = k_r; t_nxt = '0; state_nxt = S_FPRE;
      end
      S_FPRE: begin
        ctl.cmd = CMD_FIN_PRE; state_nxt = S_FSCAN;
      end
      S_FSCAN: begin
        ctl.cmd = CMD_FIN_SCAN;
        if (t_r == kmax) state_nxt = S_FCHK; else t_nxt = t_r + 1'b1;
      end
      S_FCHK: begin
        if (sts.found) state_nxt = S_BRD;
        else if (k_r == kmax) state_nxt = S_NOPATH;
        else begin k_nxt = k_r + 1'b1; state_nxt = S_FRD; end
      end
      S_BRD: begin ctl.cmd = CMD_BT_RD; state_nxt = S_BSTEP; end
      S_BSTEP: begin
        ctl.cmd = CMD_BT_STEP;
        if (sts.bt_done) state_nxt = sts.bt_bad ? S_NOPATH : S_EMIT;
        else state_nxt = S_BRD;
      end
      S_EMIT: if (out_free) begin
        emit = 1'b1; emit_last = sts.emit_last; ctl.cmd = CMD_EMIT;
        if (sts.emit_last) state_nxt = S_IDLE;
      end
      S_NOPATH: if (out_free) begin
        emit = 1'b1; emit_nopath = 1'b1; emit_last = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; func_r <= '0; k_r <= '0; t_r <= '0;
    end else begin
      state_r <= state_nxt; func_r <= func_nxt; k_r <= k_nxt; t_r <= t_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n) emit |-> out_free)
    else $error("emit without free output");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit && emit_last |=> state_r == S_IDLE) else $error("last not ending read");
  a_nopath_last: assert property (@(posedge clk) disable iff (!rst_n)
    emit_nopath |-> emit_last) else $error("no-path without last");
endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the top-K lattice path search: random and directed words.
module tb_top;
  import tkl_pkg::*;

  typedef struct packed {
    logic [15:0] choice;
    logic [31:0] score;
    logic        status;
    logic        last;
  } path_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  top_k_lattice_path_search u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow lattice and settings
  logic [4:0]  len_reg = 5'd1;
  logic [2:0]  keep_reg = 3'd1;
  logic [31:0] lat_score [128];
  logic        lat_valid [128];
  logic [1:0]  lat_prev  [128];
  logic [4:0]  lat_len   [128];
  logic [15:0] lat_choice[128];

  logic [63:0] pending_words[$];
  path_word_t  expected_path[$];
  bit          failed = 1'b0;
  bit          quiet = 1'b0;
  bit          in_taken = 1'b0;
  int          results_seen = 0;
  int          stall_left = 0;
  bit          stall_done = 1'b0;
  int          no_progress = 0;

  initial begin
    for (int i = 0; i < 128; i++) begin
      lat_valid[i] = 1'b0;
      lat_score[i] = '0;
      lat_prev[i] = '0;
      lat_len[i] = '0;
      lat_choice[i] = '0;
    end
  end

  function automatic int final_pos();
    if (len_reg == 0) return 1;
    return int'(len_reg);
  endfunction

  function automatic int kept();
    if (keep_reg == 0) return 1;
    if (keep_reg > KeepMax) return KeepMax;
    return int'(keep_reg);
  endfunction

  function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
    longint s;
    s = longint'($signed(a)) + longint'($signed(b));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  task automatic push_no_path();
    expected_path.push_back('{choice: 16'd0, score: 32'd0, status: 1'b1, last: 1'b1});
  endtask

  // Extend every kept entry at the start position by one edge
  task automatic extend_lattice(int st, int ln, logic [31:0] esc, logic [15:0] ch);
    int kk, base, src, mi;
    logic [31:0] sc;
    kk = kept();
    if (ln == 0 || st + ln > final_pos()) return;
    base = (st + ln) * KeepMax;
    for (int k = 0; k < kk; k++) begin
      src = st * KeepMax + k;
      if (!lat_valid[src]) break;
      sc = add_clamped(lat_score[src], esc);
      mi = 0;
      for (int t = 1; t < kk; t++)
        if (lat_valid[base + mi] && (!lat_valid[base + t] ||
            $signed(lat_score[base + t]) < $signed(lat_score[base + mi])))
          mi = t;
      if (!lat_valid[base + mi] || $signed(sc) > $signed(lat_score[base + mi])) begin
        lat_valid[base + mi] = 1'b1;
        lat_score[base + mi] = sc;
        lat_prev[base + mi] = k[1:0];
        lat_len[base + mi] = ln[4:0];
        lat_choice[base + mi] = ch;
      end
    end
  endtask

  // Rank final entries, backtrack, and queue the path words
  task automatic read_ranked_path(int rk);
    int kk, lp, b, place, slot, pos, idx, n;
    bit found;
    logic [31:0] total;
    logic [15:0] trail[$];
    kk = kept();
    lp = final_pos();
    b = lp * KeepMax;
    found = 0;
    slot = 0;
    if (rk >= kk) begin
      push_no_path();
      return;
    end
    for (int s = 0; s < kk && !found; s++) begin
      if (!lat_valid[b + s]) continue;
      place = 0;
      for (int t = 0; t < kk; t++) begin
        if (t == s || !lat_valid[b + t]) continue;
        if ($signed(lat_score[b + t]) > $signed(lat_score[b + s]) ||
            (lat_score[b + t] == lat_score[b + s] && t < s))
          place++;
      end
      if (place == rk) begin
        slot = s;
        found = 1;
      end
    end
    if (!found) begin
      push_no_path();
      return;
    end
    total = lat_score[b + slot];
    pos = lp;
    n = 0;
    while (pos > 0) begin
      idx = pos * KeepMax + slot;
      if (!lat_valid[idx] || lat_len[idx] == 0 || lat_len[idx] > pos || n >= 32) begin
        push_no_path();
        return;
      end
      trail.push_front(lat_choice[idx]);
      n++;
      slot = lat_prev[idx];
      pos -= lat_len[idx];
    end
    if (n == 0) begin
      push_no_path();
      return;
    end
    for (int i = 0; i < n; i++)
      expected_path.push_back('{choice: trail[i], score: total, status: 1'b0,
                                last: (i == n - 1)});
  endtask

  task automatic predict_word(logic [63:0] w);
    case (w[1:0])
      FuncStart: begin
        for (int i = 0; i < 128; i++) lat_valid[i] = 1'b0;
        lat_valid[0] = 1'b1;
        lat_score[0] = '0;
        lat_prev[0] = '0;
        lat_len[0] = '0;
        lat_choice[0] = '0;
      end
      FuncEdge: extend_lattice(w[6:2], w[11:7], w[43:12], w[59:44]);
      FuncRead: read_ranked_path(w[61:60]);
      default: ;
    endcase
  endtask

  function automatic logic [63:0] make_word(logic [1:0] f, int st, int ln,
                                            logic [31:0] sc, logic [15:0] ch, int rk);
    logic [63:0] w;
    w = {$urandom, $urandom};
    w[1:0] = f;
    w[6:2] = st[4:0];
    w[11:7] = ln[4:0];
    w[43:12] = sc;
    w[59:44] = ch;
    w[61:60] = rk[1:0];
    return w;
  endfunction

  function automatic logic [31:0] rand_score();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  // Input driver: offer the head of the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 29)) begin
        in_tvalid <= 1'b1;
        in_tdata <= pending_words[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!stall_done && results_seen >= 40) begin
      stall_done <= 1'b1;
      stall_left <= 400;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || $urandom_range(0, 99) >= 29;
    end
  end

  // Accept input words, check result words, watch for hangs
  always @(posedge clk) begin
    path_word_t got, want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        void'(pending_words.pop_front());
        predict_word(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got = '{choice: out_tdata[15:0], score: out_tdata[47:16],
                status: out_tuser, last: out_tlast};
        if (expected_path.size() == 0) begin
          $display("%0t: unexpected word %h", $realtime, got);
          failed = 1'b1;
        end else begin
          want = expected_path.pop_front();
          if (got.choice !== want.choice)
            $display("%0t: path_choice expected %h actual %h", $realtime, want.choice,
                     got.choice);
          if (got.score !== want.score)
            $display("%0t: path_score expected %h actual %h", $realtime, want.score,
                     got.score);
          if (got.status !== want.status)
            $display("%0t: status expected %b actual %b", $realtime, want.status,
                     got.status);
          if (got.last !== want.last)
            $display("%0t: last expected %b actual %b", $realtime, want.last, got.last);
          if (got !== want) failed = 1'b1;
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        no_progress <= 0;
      else
        no_progress <= no_progress + 1;
      if (no_progress >= 5000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pending_words.size() > 0 || expected_path.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == 1'b0) len_reg = val[4:0];
    else keep_reg = val[2:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lattice: start, edges in start order (some with random lengths), then reads and at times a random word
  task automatic queue_lattice();
    int lp, n;
    lp = final_pos();
    pending_words.push_back(make_word(FuncStart, 0, 0, 0, 0, 0));
    for (int p = 0; p < lp; p++) begin
      n = $urandom_range(0, 3);
      for (int e = 0; e < n; e++) begin
        if ($urandom_range(0, 9) == 0)
          pending_words.push_back(make_word(FuncEdge, p, $urandom_range(0, 31),
                                            rand_score(), $urandom, 0));
        else
          pending_words.push_back(make_word(FuncEdge, p,
                                            $urandom_range(1, lp - p > 4 ? 4 : lp - p),
                                            rand_score(), $urandom, 0));
      end
    end
    n = $urandom_range(1, 4);
    for (int r = 0; r < n; r++)
      pending_words.push_back(make_word(FuncRead, 0, 0, 0, 0, $urandom_range(0, 3)));
    if ($urandom_range(0, 4) == 0)
      pending_words.push_back({$urandom, $urandom});
  endtask

  initial begin
    int sent;
    logic [7:0] len_set[7] = '{8'd5, 8'd1, 8'd31, 8'd0, 8'd12, 8'd3, 8'd8};
    logic [7:0] keep_set[7] = '{8'd4, 8'd1, 8'd4, 8'd7, 8'd2, 8'd0, 8'd3};
    int ph;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty lattice, extremes, clamping, ties, skips, unused func
    pending_words.push_back(make_word(FuncRead, 0, 0, 0, 0, 0));
    wait_idle();
    write_reg(1'b0, 8'd5);
    write_reg(1'b1, 8'd4);
    pending_words.push_back(make_word(FuncStart, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 2, 32'h7fffffff, 16'hffff, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 2, 32'h80000000, 16'h0000, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 2, 32'd7, 16'h1234, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 2, 32'd7, 16'h4321, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 0, 32'd9, 16'h0001, 0));
    pending_words.push_back(make_word(FuncEdge, 1, 4, 32'd9, 16'h0002, 0));
    pending_words.push_back(make_word(FuncEdge, 2, 3, 32'h7fffffff, 16'haaaa, 0));
    pending_words.push_back(make_word(FuncEdge, 2, 31, 32'd1, 16'h5555, 0));
    pending_words.push_back(make_word(FuncEdge, 31, 1, 32'd1, 16'h5555, 0));
    pending_words.push_back(make_word(2'd3, 31, 31, 32'hffffffff, 16'hffff, 3));
    for (int r = 0; r < 4; r++)
      pending_words.push_back(make_word(FuncRead, 31, 31, 0, 0, r));
    pending_words.push_back(make_word(FuncStart, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 5, 32'd3, 16'h00ff, 0));
    pending_words.push_back(make_word(FuncEdge, 0, 5, 32'd3, 16'hff00, 0));
    pending_words.push_back(make_word(FuncRead, 0, 0, 0, 0, 0));
    pending_words.push_back(make_word(FuncRead, 0, 0, 0, 0, 1));
    sent = pending_words.size() + 1;
    wait_idle();

    // Random phases across settings
    ph = 0;
    while (sent < 470) begin
      write_reg(1'b0, len_set[ph % 7]);
      write_reg(1'b1, keep_set[(ph / 2) % 7]);
      quiet = (ph == 3);
      for (int j = 0; j < 4; j++) begin
        queue_lattice();
      end
      sent += pending_words.size();
      wait_idle();
      ph++;
    end
    quiet = 1'b0;
    wait_idle();
    if (!failed) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/tkl_pkg.sv
src/tkl_datapath.sv
src/tkl_ctrl.sv
src/top_k_lattice_path_search.sv
sim/tb_top.sv
